### hw/rtl/pdtq_pkg.sv
// Shared types and constants of the paced datagram transmit queue.
`timescale 1ns / 1ps
`default_nettype none
package pdtq_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [2:0] CMD_PUSH_RAW  = 3'd1;
  localparam logic [2:0] CMD_DROP      = 3'd2;
  localparam logic [2:0] CMD_TICK      = 3'd3;
  localparam logic [2:0] CMD_SEND      = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  // Status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_SENT     = 3'd2;
  localparam logic [2:0] ST_PACED    = 3'd3;
  localparam logic [2:0] ST_WAIT_BUF = 3'd4;
  localparam logic [2:0] ST_ERR_KEEP = 3'd5;
  localparam logic [2:0] ST_LOST     = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  // Register indexes
  localparam logic [2:0] REG_RATE    = 3'd0;
  localparam logic [2:0] REG_BURST   = 3'd1;
  localparam logic [2:0] REG_STALE   = 3'd2;
  localparam logic [2:0] REG_RESERVE = 3'd3;
  localparam logic [2:0] REG_CATCHUP = 3'd4;

  localparam logic [3:0] RAW_SESSION = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DROP_WALK,
    S_EXPIRE,
    S_REFILL_MUL,
    S_REFILL_DIV,
    S_REFILL_SUM,
    S_SEND_EVAL,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic decode;
    logic drop_step;
    logic drop_end;
    logic expire_step;
    logic refill_mul;
    logic refill_div;
    logic refill_sum;
    logic send_eval;
    logic finish;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       drop_more;
    logic       expire_more;
  } stat_t;

endpackage
`default_nettype wire

### hw/rtl/pdtq_ctrl.sv
// Sequencing state machine of the paced datagram transmit queue.
`timescale 1ns / 1ps
`default_nettype none
module pdtq_ctrl
  import pdtq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_DROP: state_d = S_DROP_WALK;
          CMD_TICK: state_d = S_EXPIRE;
          CMD_SEND: state_d = S_SEND_EVAL;
          default: begin
            ctrl_o.decode = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_DROP_WALK: begin
        if (stat_i.drop_more) begin
          ctrl_o.drop_step = 1'b1;
        end else begin
          ctrl_o.drop_end = 1'b1;
          state_d = S_DONE;
        end
      end
      S_EXPIRE: begin
        if (stat_i.expire_more) begin
          ctrl_o.expire_step = 1'b1;
        end else begin
          ctrl_o.refill_mul = 1'b1;
          state_d = S_REFILL_DIV;
        end
      end
      S_REFILL_MUL: begin
        ctrl_o.refill_mul = 1'b1;
        state_d = S_REFILL_DIV;
      end
      S_REFILL_DIV: begin
        ctrl_o.refill_div = 1'b1;
        state_d = S_REFILL_SUM;
      end
      S_REFILL_SUM: begin
        ctrl_o.refill_sum = 1'b1;
        state_d = S_DONE;
      end
      S_SEND_EVAL: begin
        ctrl_o.send_eval = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        ctrl_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A result strobe only ever closes a request; idle is never busy and a latched request goes to decode
  a_finish_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |-> !$past(state_q == S_IDLE))
    else $error("finish without request");
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !busy_o)
    else $error("busy while idle");
  a_latch_goes_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch_in |=> (state_q == S_DECODE))
    else $error("request not decoded");

endmodule
`default_nettype wire

### hw/rtl/pdtq_datapath.sv
// Descriptor ring, bucket, counters and result registers of the queue.
`timescale 1ns / 1ps
`default_nettype none
module pdtq_datapath
  import pdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_LENGTH  = 1078,
  parameter int SESSIONS    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [2:0]  session_i,
  input  wire logic [10:0] length_i,
  input  wire logic [7:0]  payload_tag_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        socket_open_i,
  input  wire logic        buffers_known_i,
  input  wire logic [15:0] free_buffers_i,
  input  wire logic        message_ok_i,
  input  wire logic        send_ok_i,
  input  wire logic [15:0] rate_i,
  input  wire logic [15:0] burst_i,
  input  wire logic [15:0] stale_i,
  input  wire logic [7:0]  reserve_i,
  input  wire logic [15:0] catchup_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [7:0]       tag_out_o,
  output logic [3:0]       session_out_o,
  output logic [10:0]      length_out_o,
  output logic [4:0]       queued_o,
  output logic [15:0]      credit_o,
  output logic [4:0]       dropped_now_o,
  output logic [31:0]      lost_total_o,
  output logic [31:0]      error_total_o,
  output logic [31:0]      sent_total_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PMAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(QUEUE_DEPTH);

  // Ring storage (no reset: entries below the count are always written)
  logic [31:0] at_q  [QUEUE_DEPTH];
  logic [10:0] len_q [QUEUE_DEPTH];
  logic [3:0]  ses_q [QUEUE_DEPTH];
  logic [7:0]  tag_q [QUEUE_DEPTH];
  logic        err_q [QUEUE_DEPTH];

  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   credit_q, credit_d;
  logic [31:0]   last_q, last_d;
  logic [31:0]   lost_q, lost_d, errc_q, errc_d, sent_q, sent_d;

  // Latched request
  logic [2:0]  cmd_q;
  logic [2:0]  sess_q;
  logic [10:0] len_in_q;
  logic [7:0]  tag_in_q;
  logic [31:0] now_q;
  logic        sock_q, bknown_q, msgok_q, sndok_q;
  logic [15:0] freeb_q;

  // Walk state for drop
  logic [CW-1:0] rd_q, kept_q;
  logic [4:0]    drop_q;
  // Refill pipeline
  logic [31:0]   prod_q;
  logic [15:0]   add_q;

  // Result staging
  logic [2:0]  st_q;
  logic [7:0]  otag_q;
  logic [3:0]  oses_q;
  logic [10:0] olen_q;

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] b, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, CW'(b)} + {1'b0, o};
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  logic [PW-1:0] tail_idx, prev_head, rd_idx, wr_idx, head_next;
  logic [31:0]   age;
  logic          stale;
  logic [31:0]   elapsed;
  logic [15:0]   el_cap;
  logic [16:0]   sum;
  logic [15:0]   need;
  logic [21:0]   need_prod;
  logic [10:0]   h_len;
  logic          h_raw;
  logic [58:0]   quot_prod;
  logic [31:0]   quot;
  logic          free_buffers_lt;

  assign tail_idx  = wrap(head_q, count_q);
  assign prev_head = (head_q == '0) ? PMAX : head_q - PW'(1);
  assign head_next = (head_q == PMAX) ? '0 : head_q + PW'(1);
  assign rd_idx    = wrap(head_q, rd_q);
  assign wr_idx    = wrap(head_q, kept_q);
  assign age       = now_q - at_q[head_q];
  assign stale     = !age[31] && (age > {16'd0, stale_i});
  assign elapsed   = now_q - last_q;
  assign el_cap    = (elapsed > {16'd0, catchup_i}) ? catchup_i : elapsed[15:0];
  // prod / 1000 as (prod / 8) / 125; the reciprocal of 125 is exact for x < 2^29
  assign quot_prod = {30'd0, prod_q[31:3]} * 59'd549755814;
  assign quot      = {9'd0, quot_prod[58:36]};
  assign h_len     = len_q[head_q];
  assign h_raw     = (ses_q[head_q] == RAW_SESSION);
  // length / 100 by reciprocal, exact for lengths below 2048
  assign need_prod = {11'd0, h_len} * 22'd1311;
  assign need      = {11'd0, need_prod[21:17]} + 16'd2 + {8'd0, reserve_i};
  assign sum       = {1'b0, credit_q} + {1'b0, add_q};
  assign free_buffers_lt = freeb_q < need;

  assign stat_o.cmd         = cmd_q;
  assign stat_o.drop_more   = (rd_q < count_q);
  assign stat_o.expire_more = (count_q != '0) && stale;

  // Control registers and counters
  always_comb begin
    head_d = head_q; count_d = count_q; credit_d = credit_q; last_d = last_q;
    lost_d = lost_q; errc_d = errc_q; sent_d = sent_q;
    if (ctrl_i.decode) begin
      case (cmd_q)
        CMD_PUSH_TAIL: begin
          if (!({1'b0, sess_q} >= 4'(SESSIONS) || len_in_q > 11'(MAX_LENGTH)
                || count_q >= CFULL))
            count_d = count_q + CW'(1);
        end
        CMD_PUSH_RAW: begin
          if (count_q >= CFULL || len_in_q > 11'(MAX_LENGTH)) begin
            lost_d = lost_q + 32'd1;
          end else begin
            head_d = prev_head; count_d = count_q + CW'(1);
          end
        end
        CMD_CLEAR: begin
          lost_d = lost_q + 32'(count_q); head_d = '0; count_d = '0;
        end
        default: ;
      endcase
    end
    if (ctrl_i.drop_step && ses_q[rd_idx] == {1'b0, sess_q})
      lost_d = lost_q + 32'd1;
    if (ctrl_i.drop_end) count_d = kept_q;
    if (ctrl_i.expire_step) begin
      head_d = head_next; count_d = count_q - CW'(1); lost_d = lost_q + 32'd1;
    end
    if (ctrl_i.refill_mul) last_d = now_q;
    if (ctrl_i.refill_sum) begin
      credit_d = (sum > {1'b0, burst_i}) ? burst_i : sum[15:0];
      if (count_q != '0 && !sock_q) begin
        lost_d = lost_q + 32'(count_q); head_d = '0; count_d = '0;
      end
    end
    if (ctrl_i.send_eval) begin
      if (count_q != '0 && !sock_q) begin
        lost_d = lost_q + 32'(count_q); head_d = '0; count_d = '0;
      end else if (count_q != '0) begin
        if (!h_raw && credit_q < {5'd0, h_len}) begin
        end else if (bknown_q && free_buffers_lt) begin
        end else if (!msgok_q) begin
          if (!err_q[head_q]) errc_d = errc_q + 32'd1;
        end else if (!sndok_q) begin
          if (!err_q[head_q]) errc_d = errc_q + 32'd1;
          lost_d = lost_q + 32'd1; head_d = head_next; count_d = count_q - CW'(1);
        end else begin
          sent_d = sent_q + 32'd1;
          if (!h_raw) credit_d = credit_q - {5'd0, h_len};
          head_d = head_next; count_d = count_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; count_q <= '0; credit_q <= 16'd2400; last_q <= '0;
      lost_q <= '0; errc_q <= '0; sent_q <= '0; done_o <= 1'b0;
      rd_q <= '0; kept_q <= '0; drop_q <= '0;
    end else begin
      head_q <= head_d; count_q <= count_d; credit_q <= credit_d; last_q <= last_d;
      lost_q <= lost_d; errc_q <= errc_d; sent_q <= sent_d;
      done_o <= ctrl_i.finish;
      if (ctrl_i.latch_in) begin
        rd_q <= '0; kept_q <= '0; drop_q <= '0;
      end
      if (ctrl_i.drop_step) begin
        rd_q <= rd_q + CW'(1);
        if (ses_q[rd_idx] == {1'b0, sess_q}) drop_q <= drop_q + 5'd1;
        else kept_q <= kept_q + CW'(1);
      end
      if (ctrl_i.expire_step) drop_q <= drop_q + 5'd1;
      if (ctrl_i.refill_sum && count_q != '0 && !sock_q)
        drop_q <= drop_q + 5'(count_q);
    end
  end

  // Ring writes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.decode && cmd_q == CMD_PUSH_TAIL && count_q < CFULL
        && {1'b0, sess_q} < 4'(SESSIONS) && len_in_q <= 11'(MAX_LENGTH)) begin
      at_q[tail_idx] <= now_q; len_q[tail_idx] <= len_in_q;
      ses_q[tail_idx] <= {1'b0, sess_q}; tag_q[tail_idx] <= tag_in_q;
      err_q[tail_idx] <= 1'b0;
    end
    if (ctrl_i.decode && cmd_q == CMD_PUSH_RAW && count_q < CFULL
        && len_in_q <= 11'(MAX_LENGTH)) begin
      at_q[prev_head] <= now_q; len_q[prev_head] <= len_in_q;
      ses_q[prev_head] <= RAW_SESSION; tag_q[prev_head] <= tag_in_q;
      err_q[prev_head] <= 1'b0;
    end
    if (ctrl_i.drop_step && ses_q[rd_idx] != {1'b0, sess_q}) begin
      at_q[wr_idx] <= at_q[rd_idx]; len_q[wr_idx] <= len_q[rd_idx];
      ses_q[wr_idx] <= ses_q[rd_idx]; tag_q[wr_idx] <= tag_q[rd_idx];
      err_q[wr_idx] <= err_q[rd_idx];
    end
    if (ctrl_i.send_eval && count_q != '0 && sock_q && !msgok_q
        && (h_raw || credit_q >= {5'd0, h_len}) && !(bknown_q && free_buffers_lt))
      err_q[head_q] <= 1'b1;
  end

  // Request latch, refill arithmetic and result staging
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q <= cmd_i; sess_q <= session_i; len_in_q <= length_i;
      tag_in_q <= payload_tag_i; now_q <= now_ms_i; sock_q <= socket_open_i;
      bknown_q <= buffers_known_i; freeb_q <= free_buffers_i;
      msgok_q <= message_ok_i; sndok_q <= send_ok_i;
      st_q <= ST_ACCEPTED; otag_q <= '0; oses_q <= '0; olen_q <= '0;
    end
    if (ctrl_i.refill_mul) prod_q <= {16'd0, el_cap} * {16'd0, rate_i};
    if (ctrl_i.refill_div) add_q <= (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
    if (ctrl_i.decode) begin
      case (cmd_q)
        CMD_PUSH_TAIL: begin
          otag_q <= tag_in_q; oses_q <= {1'b0, sess_q}; olen_q <= len_in_q;
          if ({1'b0, sess_q} >= 4'(SESSIONS) || len_in_q > 11'(MAX_LENGTH)
              || count_q >= CFULL) st_q <= ST_REFUSED;
        end
        CMD_PUSH_RAW: begin
          otag_q <= tag_in_q; oses_q <= RAW_SESSION; olen_q <= len_in_q;
          if (count_q >= CFULL || len_in_q > 11'(MAX_LENGTH)) st_q <= ST_LOST;
        end
        CMD_CLEAR: ;
        default: st_q <= ST_REFUSED;
      endcase
    end
    if (ctrl_i.send_eval) begin
      if (count_q == '0 || !sock_q) begin
        st_q <= ST_EMPTY;
      end else begin
        otag_q <= tag_q[head_q]; oses_q <= ses_q[head_q]; olen_q <= h_len;
        if (!h_raw && credit_q < {5'd0, h_len}) st_q <= ST_PACED;
        else if (bknown_q && free_buffers_lt) st_q <= ST_WAIT_BUF;
        else if (!msgok_q) st_q <= ST_ERR_KEEP;
        else if (!sndok_q) st_q <= ST_LOST;
        else st_q <= ST_SENT;
      end
    end
  end

  // Drop count for one-shot cases
  logic [4:0] dn_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) dn_q <= '0;
    if (ctrl_i.decode) begin
      if (cmd_q == CMD_CLEAR) dn_q <= 5'(count_q);
      else if (cmd_q == CMD_PUSH_RAW && (count_q >= CFULL || len_in_q > 11'(MAX_LENGTH)))
        dn_q <= 5'd1;
    end
    if (ctrl_i.send_eval) begin
      if (count_q != '0 && !sock_q) dn_q <= 5'(count_q);
      else if (count_q != '0 && msgok_q && !sndok_q
               && (h_raw || credit_q >= {5'd0, h_len})
               && !(bknown_q && free_buffers_lt)) dn_q <= 5'd1;
    end
  end

  assign status_o      = st_q;
  assign tag_out_o     = otag_q;
  assign session_out_o = oses_q;
  assign length_out_o  = olen_q;
  assign queued_o      = 5'(count_q);
  assign credit_o      = credit_q;
  assign dropped_now_o = dn_q + drop_q;
  assign lost_total_o  = lost_q;
  assign error_total_o = errc_q;
  assign sent_total_o  = sent_q;

  // Ring never overfills; expiry only pops from a non-empty ring; a drop never grows it
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CFULL) else $error("ring overfilled");
  a_expire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.expire_step |-> count_q != '0) else $error("expire on empty ring");
  a_drop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.drop_end |=> count_q <= $past(count_q)) else $error("drop grew ring");

endmodule
`default_nettype wire

### hw/rtl/paced_datagram_tx_queue.sv
// Top level: configuration registers, controller and datapath of the queue.
// Push, clear and unused codes are decoded and finish; send adds an evaluation
// step, drop walks every queued item, tick pops expired items, then refills.
// One request at a time; busy is high from acceptance until the result strobe,
// and the next request can be taken in the strobe cycle; none is taken before
// the last result. The receiver cannot stall: the result shows on done_o.
// Reset: ring empty, counters zero, credit 2400, registers at reset values.
`timescale 1ns / 1ps
`default_nettype none
module paced_datagram_tx_queue
  import pdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_LENGTH  = 1078,
  parameter int SESSIONS    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [2:0]  session_i,
  input  wire logic [10:0] length_i,
  input  wire logic [7:0]  payload_tag_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        socket_open_i,
  input  wire logic        buffers_known_i,
  input  wire logic [15:0] free_buffers_i,
  input  wire logic        message_ok_i,
  input  wire logic        send_ok_i,
  output logic [2:0]       status_o,
  output logic [7:0]       tag_out_o,
  output logic [3:0]       session_out_o,
  output logic [10:0]      length_out_o,
  output logic [4:0]       queued_o,
  output logic [15:0]      credit_o,
  output logic [4:0]       dropped_now_o,
  output logic [31:0]      lost_total_o,
  output logic [31:0]      error_total_o,
  output logic [31:0]      sent_total_o
);

  logic [15:0] rate_q, burst_q, stale_q, catchup_q;
  logic [7:0]  reserve_q;
  logic [2:0]  ridx;
  logic        wr;
  ctrl_t       ctrl;
  stat_t       stat;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 16'd3000; burst_q <= 16'd2400; stale_q <= 16'd4000;
      reserve_q <= 8'd24; catchup_q <= 16'd10000;
    end else if (wr) begin
      case (ridx)
        REG_RATE:    rate_q    <= pwdata[15:0];
        REG_BURST:   burst_q   <= pwdata[15:0];
        REG_STALE:   stale_q   <= pwdata[15:0];
        REG_RESERVE: reserve_q <= pwdata[7:0];
        REG_CATCHUP: catchup_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (ridx)
      REG_RATE:    prdata = {16'd0, rate_q};
      REG_BURST:   prdata = {16'd0, burst_q};
      REG_STALE:   prdata = {16'd0, stale_q};
      REG_RESERVE: prdata = {24'd0, reserve_q};
      REG_CATCHUP: prdata = {16'd0, catchup_q};
      default:     prdata = '0;
    endcase
  end

  pdtq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  pdtq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_LENGTH(MAX_LENGTH), .SESSIONS(SESSIONS)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .session_i, .length_i, .payload_tag_i, .now_ms_i, .socket_open_i,
    .buffers_known_i, .free_buffers_i, .message_ok_i, .send_ok_i,
    .rate_i(rate_q), .burst_i(burst_q), .stale_i(stale_q), .reserve_i(reserve_q),
    .catchup_i(catchup_q), .done_o,
    .status_o, .tag_out_o, .session_out_o, .length_out_o, .queued_o, .credit_o,
    .dropped_now_o, .lost_total_o, .error_total_o, .sent_total_o
  );

endmodule
`default_nettype wire

### tb/pdtq_checker.sv
// Checker for the paced datagram transmit queue: predicts each result and compares it.
`timescale 1ns / 1ps
module pdtq_checker
  import pdtq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        done_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic        pready_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [2:0]  session_i,
  input  wire logic [10:0] length_i,
  input  wire logic [7:0]  payload_tag_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        socket_open_i,
  input  wire logic        buffers_known_i,
  input  wire logic [15:0] free_buffers_i,
  input  wire logic        message_ok_i,
  input  wire logic        send_ok_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [7:0]  tag_out_i,
  input  wire logic [3:0]  session_out_i,
  input  wire logic [10:0] length_out_i,
  input  wire logic [4:0]  queued_i,
  input  wire logic [15:0] credit_i,
  input  wire logic [4:0]  dropped_now_i,
  input  wire logic [31:0] lost_total_i,
  input  wire logic [31:0] error_total_i,
  input  wire logic [31:0] sent_total_i,
  output int               fail_count_o,
  output int               awaiting_o
);

  localparam int DEPTH      = 8;
  localparam int LEN_LIMIT  = 1078;
  localparam int N_SESSIONS = 4;

  typedef struct {
    logic [31:0] stamp;
    logic [10:0] len;
    logic [3:0]  sess;
    logic [7:0]  tag;
    bit          marked;
  } dgram_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  tag;
    logic [3:0]  sess;
    logic [10:0] len;
    logic [4:0]  queued;
    logic [15:0] credit;
    logic [4:0]  dropped;
    logic [31:0] lost;
    logic [31:0] errors;
    logic [31:0] sent;
  } outcome_t;

  // Model copy of the queue
  dgram_t      ring[DEPTH];
  int          head, count;
  logic [15:0] credit_m;
  logic [31:0] last_refill, lost_m, err_m, sent_m;
  logic [15:0] rate_r, burst_r, stale_r, catchup_r;
  logic [7:0]  reserve_r;

  outcome_t due_q[$];

  initial begin
    head = 0; count = 0; credit_m = 16'd2400; last_refill = '0;
    lost_m = '0; err_m = '0; sent_m = '0;
    rate_r = 16'd3000; burst_r = 16'd2400; stale_r = 16'd4000;
    reserve_r = 8'd24; catchup_r = 16'd10000;
    fail_count_o = 0; awaiting_o = 0;
  end

  function automatic int slot(int i);
    return (head + i) % DEPTH;
  endfunction

  // Drops every queued datagram as lost, returns how many
  function automatic int flush_ring();
    int n;
    n = count;
    lost_m = lost_m + 32'(n);
    head = 0;
    count = 0;
    return n;
  endfunction

  function automatic outcome_t predict_outcome();
    outcome_t    o;
    logic [31:0] age, elapsed;
    logic [63:0] add, sum;
    int          kept, from;
    o = '{default: '0};
    o.status = ST_ACCEPTED;
    case (cmd_i)
      CMD_PUSH_TAIL: begin
        o.tag = payload_tag_i; o.sess = {1'b0, session_i}; o.len = length_i;
        if (session_i >= N_SESSIONS || length_i > LEN_LIMIT || count >= DEPTH)
          o.status = ST_REFUSED;
        else begin
          ring[slot(count)] = '{now_ms_i, length_i, {1'b0, session_i}, payload_tag_i, 0};
          count++;
        end
      end
      CMD_PUSH_RAW: begin
        o.tag = payload_tag_i; o.sess = RAW_SESSION; o.len = length_i;
        if (count >= DEPTH || length_i > LEN_LIMIT) begin
          lost_m++; o.dropped = 5'd1; o.status = ST_LOST;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          count++;
          ring[head] = '{now_ms_i, length_i, RAW_SESSION, payload_tag_i, 0};
        end
      end
      CMD_DROP: begin
        kept = 0;
        for (int i = 0; i < count; i++) begin
          from = slot(i);
          if (ring[from].sess == {1'b0, session_i}) begin
            lost_m++; o.dropped++;
          end else begin
            ring[slot(kept)] = ring[from];
            kept++;
          end
        end
        count = kept;
      end
      CMD_TICK: begin
        // expiry stops at the first fresh head
        while (count != 0) begin
          age = now_ms_i - ring[head].stamp;
          if (age[31] || age <= {16'd0, stale_r}) break;
          head = (head + 1) % DEPTH; count--;
          lost_m++; o.dropped++;
        end
        elapsed = now_ms_i - last_refill;
        last_refill = now_ms_i;
        if (elapsed > {16'd0, catchup_r}) elapsed = {16'd0, catchup_r};
        add = 64'(elapsed) * 64'(rate_r) / 64'd1000;
        sum = 64'(credit_m) + add;
        credit_m = (sum > 64'(burst_r)) ? burst_r : sum[15:0];
        if (count != 0 && !socket_open_i) o.dropped = o.dropped + 5'(flush_ring());
      end
      CMD_SEND: begin
        if (count != 0 && !socket_open_i) o.dropped = o.dropped + 5'(flush_ring());
        if (count == 0) o.status = ST_EMPTY;
        else begin
          o.tag = ring[head].tag; o.sess = ring[head].sess; o.len = ring[head].len;
          if (ring[head].sess != RAW_SESSION && credit_m < 16'(ring[head].len))
            o.status = ST_PACED;
          else if (buffers_known_i && 32'(free_buffers_i) <
                   32'(ring[head].len) / 100 + 2 + 32'(reserve_r))
            o.status = ST_WAIT_BUF;
          else if (!message_ok_i) begin
            if (!ring[head].marked) err_m++;
            ring[head].marked = 1;
            o.status = ST_ERR_KEEP;
          end else if (!send_ok_i) begin
            if (!ring[head].marked) err_m++;
            lost_m++; o.dropped = 5'd1;
            head = (head + 1) % DEPTH; count--;
            o.status = ST_LOST;
          end else begin
            sent_m++;
            if (ring[head].sess != RAW_SESSION) credit_m -= 16'(ring[head].len);
            head = (head + 1) % DEPTH; count--;
            o.status = ST_SENT;
          end
        end
      end
      CMD_CLEAR: o.dropped = 5'(flush_ring());
      default: o.status = ST_REFUSED;
    endcase
    o.queued = 5'(count); o.credit = credit_m;
    o.lost = lost_m; o.errors = err_m; o.sent = sent_m;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // Track register writes, requests and results
  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        case (paddr_i[4:2])
          REG_RATE:    rate_r    = pwdata_i[15:0];
          REG_BURST:   burst_r   = pwdata_i[15:0];
          REG_STALE:   stale_r   = pwdata_i[15:0];
          REG_RESERVE: reserve_r = pwdata_i[7:0];
          REG_CATCHUP: catchup_r = pwdata_i[15:0];
          default: ;
        endcase
      if (done_i) begin
        if (due_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual status %0d", $time,
                   status_i);
          fail_count_o++;
        end else begin
          w = due_q.pop_front();
          check_field("status", 32'(w.status), 32'(status_i));
          check_field("tag_out", 32'(w.tag), 32'(tag_out_i));
          check_field("session_out", 32'(w.sess), 32'(session_out_i));
          check_field("length_out", 32'(w.len), 32'(length_out_i));
          check_field("queued", 32'(w.queued), 32'(queued_i));
          check_field("credit", 32'(w.credit), 32'(credit_i));
          check_field("dropped_now", 32'(w.dropped), 32'(dropped_now_i));
          check_field("lost_total", w.lost, lost_total_i);
          check_field("error_total", w.errors, error_total_i);
          check_field("sent_total", w.sent, sent_total_i);
        end
      end
      if (start_i && !busy_i) due_q.push_back(predict_outcome());
      awaiting_o = due_q.size();
    end
  end

endmodule

### tb/tb.sv
// Testbench top: stimulus, register set-up and verdict for the datagram queue.
`timescale 1ns / 1ps
module tb;
  import pdtq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 0, rst_n = 0, start = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [2:0]  cmd = '0, sess = '0;
  logic [10:0] len = '0;
  logic [7:0]  tag = '0;
  logic [31:0] now = '0;
  logic        sock = 1, bknown = 0, mok = 1, sok = 1;
  logic [15:0] freeb = '0;
  wire         busy, done, pready;
  wire  [31:0] prdata;
  wire  [2:0]  status;
  wire  [7:0]  tag_out;
  wire  [3:0]  sess_out;
  wire  [10:0] len_out;
  wire  [4:0]  queued, dropped;
  wire  [15:0] credit;
  wire  [31:0] lost_tot, err_tot, sent_tot;
  int          fails, awaiting, quiet_cycles;
  logic [31:0] clock_ms;
  bit          no_gaps;

  always #1 clk = ~clk;

  paced_datagram_tx_queue uut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .done_o(done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .cmd_i(cmd), .session_i(sess), .length_i(len), .payload_tag_i(tag), .now_ms_i(now),
    .socket_open_i(sock), .buffers_known_i(bknown), .free_buffers_i(freeb),
    .message_ok_i(mok), .send_ok_i(sok),
    .status_o(status), .tag_out_o(tag_out), .session_out_o(sess_out),
    .length_out_o(len_out), .queued_o(queued), .credit_o(credit),
    .dropped_now_o(dropped), .lost_total_o(lost_tot), .error_total_o(err_tot),
    .sent_total_o(sent_tot)
  );

  pdtq_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .done_i(done),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .cmd_i(cmd), .session_i(sess), .length_i(len), .payload_tag_i(tag), .now_ms_i(now),
    .socket_open_i(sock), .buffers_known_i(bknown), .free_buffers_i(freeb),
    .message_ok_i(mok), .send_ok_i(sok),
    .status_i(status), .tag_out_i(tag_out), .session_out_i(sess_out),
    .length_out_i(len_out), .queued_i(queued), .credit_i(credit),
    .dropped_now_i(dropped), .lost_total_i(lost_tot), .error_total_i(err_tot),
    .sent_total_i(sent_tot), .fail_count_o(fails), .awaiting_o(awaiting)
  );

  // Watchdog: cycles without any request, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || done || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Issue one request once the queue is free, idling some free cycles at random
  task automatic issue(logic [2:0] c, logic [2:0] s, logic [10:0] l, logic [7:0] t,
                       logic [31:0] n, logic so, logic bk, logic [15:0] fb,
                       logic mo, logic sk);
    @(posedge clk);
    while (busy || (!no_gaps && $urandom_range(0, 99) < 37)) @(posedge clk);
    start <= 1; cmd <= c; sess <= s; len <= l; tag <= t; now <= n;
    sock <= so; bknown <= bk; freeb <= fb; mok <= mo; sok <= sk;
    // the queue is idle, so the request is taken at the next edge
    @(posedge clk);
    start <= 0;
  endtask

  // Wait until the queue is idle with nothing outstanding
  task automatic settle();
    @(posedge clk);
    while (busy || awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic load_regs(logic [15:0] r, logic [15:0] b, logic [15:0] st,
                           logic [7:0] rs, logic [15:0] cu);
    settle();
    reg_write(REG_RATE, {16'hFFFF, r});
    reg_write(REG_BURST, {16'hA5A5, b});
    reg_write(REG_STALE, {16'h0000, st});
    reg_write(REG_RESERVE, {24'hFFFFFF, rs});
    reg_write(REG_CATCHUP, {16'h5A5A, cu});
  endtask

  // One random request, mostly well formed with advancing time
  task automatic random_request();
    int          pick;
    logic [2:0]  c, s;
    logic [10:0] l;
    logic [15:0] fb;
    pick = $urandom_range(0, 99);
    if (pick < 30) c = CMD_PUSH_TAIL;
    else if (pick < 38) c = CMD_PUSH_RAW;
    else if (pick < 44) c = CMD_DROP;
    else if (pick < 59) c = CMD_TICK;
    else if (pick < 95) c = CMD_SEND;
    else if (pick < 98) c = CMD_CLEAR;
    else c = 3'($urandom_range(6, 7));
    s = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3)) : 3'($urandom);
    l = ($urandom_range(0, 99) < 85) ? 11'($urandom_range(0, 1078)) : 11'($urandom);
    fb = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 60)) : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 5) clock_ms -= $urandom_range(1, 5000);
    else if (pick < 10) clock_ms += $urandom_range(1000, 20000);
    else clock_ms += $urandom_range(0, 300);
    issue(c, s, l, 8'($urandom), clock_ms, $urandom_range(0, 99) < 95,
          $urandom_range(0, 99) < 80, fb, $urandom_range(0, 99) < 88,
          $urandom_range(0, 99) < 88);
  endtask

  initial begin
    logic [15:0] r, b, st, cu;
    logic [7:0]  rs;
    quiet_cycles = 0;
    no_gaps = 0;
    clock_ms = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: refusals, extremes, pacing, buffers, errors, stale, socket loss
    issue(CMD_SEND, 0, 0, 0, 0, 1, 0, 0, 1, 1);                 // empty ring
    issue(CMD_PUSH_TAIL, 0, 0, 8'h00, 100, 1, 0, 0, 1, 1);
    issue(CMD_PUSH_TAIL, 3, 1078, 8'hFF, 110, 1, 0, 0, 1, 1);
    issue(CMD_PUSH_TAIL, 4, 10, 8'h11, 120, 1, 0, 0, 1, 1);     // bad session
    issue(CMD_PUSH_TAIL, 7, 2047, 8'h22, 120, 1, 0, 0, 1, 1);
    issue(CMD_PUSH_TAIL, 1, 1079, 8'h33, 130, 1, 0, 0, 1, 1);   // too long
    issue(CMD_PUSH_RAW, 5, 2047, 8'h44, 140, 1, 0, 0, 1, 1);    // raw too long
    issue(CMD_PUSH_RAW, 0, 60, 8'h55, 150, 1, 0, 0, 1, 1);
    issue(CMD_SEND, 0, 0, 0, 160, 1, 1, 16'd0, 1, 1);           // waiting buffers
    issue(CMD_SEND, 0, 0, 0, 170, 1, 1, 16'hFFFF, 0, 1);        // message failure
    issue(CMD_SEND, 0, 0, 0, 180, 1, 0, 0, 0, 1);               // no recount
    issue(CMD_SEND, 0, 0, 0, 190, 1, 0, 0, 1, 0);               // refused, lost
    for (int i = 0; i < 7; i++)
      issue(CMD_PUSH_TAIL, 3'(i % 4), 11'(1000 + i), 8'(i), 200, 1, 0, 0, 1, 1);
    issue(CMD_PUSH_RAW, 0, 5, 8'h66, 210, 1, 0, 0, 1, 1);       // full ring
    issue(CMD_SEND, 0, 0, 0, 220, 1, 0, 0, 1, 1);               // paced or sent
    issue(CMD_DROP, 1, 0, 0, 230, 1, 0, 0, 1, 1);
    issue(CMD_TICK, 0, 0, 0, 32'd9000, 1, 0, 0, 1, 1);          // stale expiry
    issue(CMD_PUSH_TAIL, 2, 7, 8'h77, 32'hFFFF_FFF0, 1, 0, 0, 1, 1);
    issue(CMD_TICK, 0, 0, 0, 32'd20, 0, 0, 0, 1, 1);            // socket closed
    issue(CMD_CLEAR, 0, 0, 0, 30, 1, 0, 0, 1, 1);
    issue(3'd6, 0, 0, 0, 40, 1, 0, 0, 1, 1);
    issue(3'd7, 0, 0, 0, 50, 1, 0, 0, 1, 1);
    clock_ms = 50;

    // Random phases across register settings: reset values, then extremes, then random
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: load_regs(16'd65535, 16'd65535, 16'd1, 8'd255, 16'd1);
        2: load_regs(16'd1, 16'd1, 16'd65535, 8'd0, 16'd65535);
        default: begin
          r = 16'($urandom_range(1, 65535)); b = 16'($urandom_range(1, 65535));
          st = 16'($urandom_range(1, 65535)); rs = 8'($urandom);
          cu = 16'($urandom_range(1, 65535));
          load_regs(r, b, st, rs, cu);
        end
      endcase
      for (int i = 0; i < 260; i++) begin
        no_gaps = (ph == 1 && i >= 60 && i < 200);
        random_request();
      end
    end

    settle();
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
